// ===== design/tdim_pkg.sv =====
// types, codes and default sizes shared by the tag-to-dense-index map
// no dependencies; used by tdim_ctrl, tdim_dp and tag_to_dense_index_map_top
`timescale 1ns / 1ps
`default_nettype none

package tdim_pkg;

  localparam int TAG_SPACE_DEF   = 4096;
  localparam int ENTRY_SPACE_DEF = 1024;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TAG_AT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_POS_OF  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POS_RANGE   = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WR2,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec;
    logic wr2;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_wr2;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/tdim_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tdim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/tdim_ctrl.sv =====
// operation sequencer for the tag-to-dense-index map
// uses tdim_pkg state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module tdim_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tdim_pkg::stat_t stat,
  output tdim_pkg::cmd_t      cmd
);

  tdim_pkg::state_t state_r;
  tdim_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdim_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdim_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = tdim_pkg::S_IDLE;
      end
      tdim_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tdim_pkg::S_EXEC;
      end
      tdim_pkg::S_EXEC: begin
        state_nxt = stat.need_wr2 ? tdim_pkg::S_WR2 : tdim_pkg::S_DONE;
      end
      tdim_pkg::S_WR2: begin
        state_nxt = tdim_pkg::S_DONE;
      end
      tdim_pkg::S_DONE: begin
        if (stat.out_free) state_nxt = tdim_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tdim_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      tdim_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      tdim_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tdim_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      tdim_pkg::S_WR2: begin
        cmd.wr2 = 1'b1;
      end
      tdim_pkg::S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a transfer on the input always moves straight into execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == tdim_pkg::S_EXEC))
    else $error("accepted transfer not executed");

  // the clearing pass never runs again once it has finished
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tdim_pkg::S_CLEAR) |=> (state_r != tdim_pkg::S_CLEAR))
    else $error("clearing pass restarted");

  // exec with a second write always passes through the second write cycle
  a_wr2_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && stat.need_wr2) |=> cmd.wr2)
    else $error("second write skipped");

endmodule

`default_nettype wire

// ===== design/tdim_dp.sv =====
// datapath: both lookup tables, counters, operation decode and result register
// uses tdim_pkg codes and command/status types, instantiates tdim_ram twice
`timescale 1ns / 1ps
`default_nettype none

module tdim_dp #(
  parameter int TAG_SPACE   = tdim_pkg::TAG_SPACE_DEF,
  parameter int ENTRY_SPACE = tdim_pkg::ENTRY_SPACE_DEF,
  localparam int TAG_W = $clog2(TAG_SPACE),
  localparam int POS_W = $clog2(ENTRY_SPACE),
  localparam int CNT_W = $clog2(ENTRY_SPACE + 1),
  localparam int HW_W  = $clog2(TAG_SPACE + 1),
  localparam int VAL_W = ((TAG_W > POS_W) ? TAG_W : POS_W) + 1,
  localparam int MT_W  = TAG_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tdim_pkg::cmd_t                cmd,
  output tdim_pkg::stat_t                    stat,
  input  wire logic [tdim_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [TAG_W-1:0]              in_tag,
  input  wire logic [POS_W-1:0]              in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tdim_pkg::STATUS_W-1:0] out_status,
  output logic signed [VAL_W-1:0]            out_value,
  output logic                               out_exists,
  output logic      [CNT_W-1:0]              out_entry_count,
  output logic signed [MT_W-1:0]             out_max_tag
);

  localparam logic [VAL_W-1:0] VAL_NONE  = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] VAL_RANGE = {{(VAL_W-1){1'b1}}, 1'b0};

  // latched operation
  logic [tdim_pkg::FUNC_W-1:0] func_r;
  logic [TAG_W-1:0]            tag_r;
  logic [POS_W-1:0]            pos_r;

  // map state
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] pu_r, pu_nxt;
  logic [HW_W-1:0]  hw_r, hw_nxt;
  logic [HW_W-1:0]  ttl_r, ttl_nxt;
  logic [TAG_W-1:0] clr_cnt_r;

  // result holding and output register
  logic [tdim_pkg::STATUS_W-1:0] res_status_r, res_status;
  logic [VAL_W-1:0]              res_value_r, res_value;
  logic                          res_exists_r, res_exists;
  logic                          out_valid_r;
  logic [tdim_pkg::STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]              out_value_r;
  logic                          out_exists_r;
  logic [CNT_W-1:0]              out_count_r;
  logic [MT_W-1:0]               out_max_tag_r;

  // tag table: valid bit over position; position table: valid bit over tag
  logic             t2p_we, p2t_we;
  logic [TAG_W-1:0] t2p_waddr;
  logic [POS_W-1:0] p2t_waddr;
  logic [POS_W:0]   t2p_wdata, t2p_rd;
  logic [TAG_W:0]   p2t_wdata, p2t_rd;
  logic [POS_W-1:0] p2t_raddr;

  logic             ex_t2p_we, ex_p2t_we;
  logic [TAG_W-1:0] ex_t2p_addr;
  logic [POS_W-1:0] ex_p2t_addr;
  logic [POS_W:0]   ex_t2p_data;
  logic [TAG_W:0]   ex_p2t_data;
  logic             need_wr2;

  logic             t2p_vld, p2t_vld;
  logic [POS_W-1:0] t2p_pos;
  logic [TAG_W-1:0] p2t_tag;
  logic [HW_W-1:0]  tag_ext, tag_p1, hw_p1;
  logic [CNT_W-1:0] live_p1, live_m1, pos_ext;
  logic             is_remove;

  assign t2p_vld   = t2p_rd[POS_W];
  assign t2p_pos   = t2p_rd[POS_W-1:0];
  assign p2t_vld   = p2t_rd[TAG_W];
  assign p2t_tag   = p2t_rd[TAG_W-1:0];
  assign tag_ext   = HW_W'(tag_r);
  assign tag_p1    = tag_ext + HW_W'(1);
  assign hw_p1     = hw_r + HW_W'(1);
  assign live_p1   = live_r + CNT_W'(1);
  assign live_m1   = live_r - CNT_W'(1);
  assign pos_ext   = CNT_W'(pos_r);
  assign is_remove = (func_r == tdim_pkg::FUNC_REMOVE);

  // remove reads the last live slot, everything else the given position
  assign p2t_raddr = (in_func == tdim_pkg::FUNC_REMOVE) ?
                     ((live_r == '0) ? '0 : live_m1[POS_W-1:0]) : in_position;

  tdim_ram #(.WIDTH(POS_W + 1), .DEPTH(TAG_SPACE)) u_t2p (
    .clk   (clk),
    .we    (t2p_we),
    .waddr (t2p_waddr),
    .wdata (t2p_wdata),
    .re    (cmd.accept),
    .raddr (in_tag),
    .rdata (t2p_rd)
  );

  tdim_ram #(.WIDTH(TAG_W + 1), .DEPTH(ENTRY_SPACE)) u_p2t (
    .clk   (clk),
    .we    (p2t_we),
    .waddr (p2t_waddr),
    .wdata (p2t_wdata),
    .re    (cmd.accept),
    .raddr (p2t_raddr),
    .rdata (p2t_rd)
  );

  // operation decode, valid in the exec cycle when read data is back
  always_comb begin
    res_status  = tdim_pkg::ST_OK;
    res_value   = VAL_NONE;
    res_exists  = 1'b0;
    need_wr2    = 1'b0;
    ex_t2p_we   = 1'b0;
    ex_t2p_addr = tag_r;
    ex_t2p_data = '0;
    ex_p2t_we   = 1'b0;
    ex_p2t_addr = pos_r;
    ex_p2t_data = '0;
    live_nxt    = live_r;
    pu_nxt      = pu_r;
    hw_nxt      = hw_r;
    ttl_nxt     = ttl_r;
    case (func_r)
      tdim_pkg::FUNC_ADD: begin
        if (hw_r >= HW_W'(TAG_SPACE)) begin
          res_status = tdim_pkg::ST_EXHAUSTED;
        end else if (live_r >= CNT_W'(ENTRY_SPACE)) begin
          res_status = tdim_pkg::ST_FULL;
        end else begin
          ex_t2p_we   = 1'b1;
          ex_t2p_addr = hw_r[TAG_W-1:0];
          ex_t2p_data = {1'b1, live_r[POS_W-1:0]};
          ex_p2t_we   = 1'b1;
          ex_p2t_addr = live_r[POS_W-1:0];
          ex_p2t_data = {1'b1, hw_r[TAG_W-1:0]};
          ttl_nxt     = (hw_p1 > ttl_r) ? hw_p1 : ttl_r;
          pu_nxt      = (live_p1 > pu_r) ? live_p1 : pu_r;
          live_nxt    = live_p1;
          hw_nxt      = hw_p1;
          res_value   = VAL_W'(hw_r);
        end
      end
      tdim_pkg::FUNC_REMOVE: begin
        if (!(tag_ext < ttl_r) || !t2p_vld || live_r == '0) begin
          res_status = tdim_pkg::ST_NOT_PRESENT;
        end else begin
          // last entry's tag now points at the freed slot
          live_nxt    = live_m1;
          ex_t2p_we   = p2t_vld;
          ex_t2p_addr = p2t_tag;
          ex_t2p_data = {1'b1, t2p_pos};
          ex_p2t_we   = 1'b1;
          ex_p2t_addr = t2p_pos;
          ex_p2t_data = p2t_rd;
          need_wr2    = 1'b1;
          res_value   = VAL_W'(t2p_pos);
        end
      end
      tdim_pkg::FUNC_SET: begin
        if (!(pos_ext < pu_r) || !(tag_ext < HW_W'(TAG_SPACE))) begin
          res_status = tdim_pkg::ST_POS_RANGE;
        end else begin
          ex_p2t_we   = 1'b1;
          ex_p2t_addr = pos_r;
          ex_p2t_data = {1'b1, tag_r};
          ex_t2p_we   = p2t_vld;
          ex_t2p_addr = p2t_tag;
          ex_t2p_data = '0;
          ttl_nxt     = (tag_p1 > ttl_r) ? tag_p1 : ttl_r;
          if (hw_r <= tag_ext) begin
            hw_nxt = tag_p1;
          end else if (p2t_vld && (hw_r - HW_W'(1)) == HW_W'(p2t_tag)) begin
            hw_nxt = hw_r - HW_W'(1);
          end
          need_wr2  = 1'b1;
          res_value = p2t_vld ? VAL_W'(p2t_tag) : VAL_NONE;
        end
      end
      tdim_pkg::FUNC_TAG_AT: begin
        if (pos_ext >= live_r) begin
          res_status = tdim_pkg::ST_POS_RANGE;
          res_value  = VAL_RANGE;
        end else begin
          res_value = p2t_vld ? VAL_W'(p2t_tag) : VAL_NONE;
        end
      end
      tdim_pkg::FUNC_POS_OF: begin
        if (tag_ext >= ttl_r) begin
          res_status = tdim_pkg::ST_NOT_PRESENT;
          res_value  = VAL_RANGE;
        end else if (t2p_vld) begin
          res_value  = VAL_W'(t2p_pos);
          res_exists = 1'b1;
        end else begin
          res_status = tdim_pkg::ST_NOT_PRESENT;
        end
      end
      default: begin
        res_status = tdim_pkg::ST_OK;
      end
    endcase
  end

  // write port selection: clearing pass, first write, second write
  always_comb begin
    t2p_we    = 1'b0;
    t2p_waddr = tag_r;
    t2p_wdata = '0;
    p2t_we    = 1'b0;
    p2t_waddr = pos_r;
    p2t_wdata = '0;
    if (cmd.clr_en) begin
      t2p_we    = 1'b1;
      t2p_waddr = clr_cnt_r;
    end else if (cmd.exec) begin
      t2p_we    = ex_t2p_we;
      t2p_waddr = ex_t2p_addr;
      t2p_wdata = ex_t2p_data;
      p2t_we    = ex_p2t_we;
      p2t_waddr = ex_p2t_addr;
      p2t_wdata = ex_p2t_data;
    end else if (cmd.wr2) begin
      // live_r is already decremented for remove, so it names the old last slot
      t2p_we    = 1'b1;
      t2p_waddr = tag_r;
      t2p_wdata = is_remove ? '0 : {1'b1, pos_r};
      p2t_we    = is_remove;
      p2t_waddr = live_r[POS_W-1:0];
      p2t_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      pu_r        <= '0;
      hw_r        <= '0;
      ttl_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + TAG_W'(1);
      end
      if (cmd.exec) begin
        live_r <= live_nxt;
        pu_r   <= pu_nxt;
        hw_r   <= hw_nxt;
        ttl_r  <= ttl_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      tag_r  <= in_tag;
      pos_r  <= in_position;
    end
    if (cmd.exec) begin
      res_status_r <= res_status;
      res_value_r  <= res_value;
      res_exists_r <= res_exists;
    end
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_value_r   <= res_value_r;
      out_exists_r  <= res_exists_r;
      out_count_r   <= live_r;
      out_max_tag_r <= MT_W'(hw_r) - MT_W'(1);
    end
  end

  assign stat.clr_last = (clr_cnt_r == TAG_W'(TAG_SPACE - 1));
  assign stat.need_wr2 = need_wr2;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value       = out_value_r;
  assign out_exists      = out_exists_r;
  assign out_entry_count = out_count_r;
  assign out_max_tag     = out_max_tag_r;

  // a result appears only through a load from the holding registers
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result appeared without load");

  // live count moves only in the exec cycle
  a_live_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != $past(live_r)) |-> $past(cmd.exec))
    else $error("live count changed outside exec");

  // every live slot lies below the written-positions bound
  a_live_pu: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= pu_r)
    else $error("live count above positions used");

  // the tag table length always covers the high-water mark
  a_hw_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r <= ttl_r)
    else $error("high-water mark above tag table length");

endmodule

`default_nettype wire

// ===== design/tag_to_dense_index_map_top.sv =====
// top level of the tag-to-dense-index map (slot map with swap-remove)
// uses tdim_pkg, instantiates tdim_ctrl and tdim_dp
//
//   channel  signals                                              direction
//   in       in_valid/in_ready, in_func, in_tag, in_position       sink
//   out      out_valid/out_ready, out_status, out_value,           source
//            out_exists, out_entry_count, out_max_tag
//
// add, both lookups, unused codes and a failed remove or set go from exec to done; a
// successful remove or set passes the second write state in between: the tables
// are single write port rams and those two operations can write the tag table twice.
// the next transfer is taken once the result sits in the output register. after reset
// the tag table is cleared one entry per cycle, TAG_SPACE entries (4096 by default),
// with in_ready low. a stalled output holds its result while the next item executes.
`timescale 1ns / 1ps
`default_nettype none

module tag_to_dense_index_map_top #(
  parameter int TAG_SPACE   = tdim_pkg::TAG_SPACE_DEF,
  parameter int ENTRY_SPACE = tdim_pkg::ENTRY_SPACE_DEF,
  localparam int TAG_W = $clog2(TAG_SPACE),
  localparam int POS_W = $clog2(ENTRY_SPACE),
  localparam int CNT_W = $clog2(ENTRY_SPACE + 1),
  localparam int VAL_W = ((TAG_W > POS_W) ? TAG_W : POS_W) + 1,
  localparam int MT_W  = TAG_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tdim_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [TAG_W-1:0]              in_tag,
  input  wire logic [POS_W-1:0]              in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tdim_pkg::STATUS_W-1:0] out_status,
  output logic signed [VAL_W-1:0]            out_value,
  output logic                               out_exists,
  output logic      [CNT_W-1:0]              out_entry_count,
  output logic signed [MT_W-1:0]             out_max_tag
);

  tdim_pkg::cmd_t  cmd;
  tdim_pkg::stat_t stat;

  tdim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdim_dp #(
    .TAG_SPACE   (TAG_SPACE),
    .ENTRY_SPACE (ENTRY_SPACE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_tag          (in_tag),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_exists      (out_exists),
    .out_entry_count (out_entry_count),
    .out_max_tag     (out_max_tag)
  );

endmodule

`default_nettype wire

// ===== tb/tag_to_dense_index_map_top_tb.sv =====
// self-checking testbench for tag_to_dense_index_map_top: a slot map model predicts every result
// depends on tdim_pkg and the design sources; driver and monitor are clocked always blocks
`timescale 1ns / 1ps

module tag_to_dense_index_map_top_tb;

  localparam int TAG_N       = tdim_pkg::TAG_SPACE_DEF;
  localparam int ENTRY_N     = tdim_pkg::ENTRY_SPACE_DEF;
  localparam int RAND_ITEMS  = 520;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] tag;
    logic [9:0]  pos;
  } map_op_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [12:0] value;
    logic               exists;
    logic [10:0]        count;
    logic signed [12:0] max_tag;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [2:0] in_func = '0;
  logic [11:0] in_tag = '0;
  logic [9:0] in_position = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [2:0] out_status;
  logic signed [12:0] out_value;
  logic out_exists;
  logic [10:0] out_entry_count;
  logic signed [12:0] out_max_tag;

  tag_to_dense_index_map_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_tag(in_tag), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_value(out_value), .out_exists(out_exists),
    .out_entry_count(out_entry_count), .out_max_tag(out_max_tag)
  );

  always #5 clk = ~clk;

  // shadow slot map
  int tag_pos [TAG_N];
  int pos_tag [ENTRY_N];
  int live_n, tag_hw, tag_len, pos_used;

  map_op_t     pending_ops[$];
  map_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;

  function automatic map_result_t slotmap_apply(logic [2:0] f, logic [11:0] t, logic [9:0] p);
    map_result_t r;
    int ti, pi, idx, moved, old, v;
    ti = t;
    pi = p;
    v = -1;
    r.status = tdim_pkg::ST_OK;
    r.exists = 1'b0;
    case (f)
      tdim_pkg::FUNC_ADD: begin
        if (tag_hw >= TAG_N) begin
          r.status = tdim_pkg::ST_EXHAUSTED;
        end else if (live_n >= ENTRY_N) begin
          r.status = tdim_pkg::ST_FULL;
        end else begin
          tag_pos[tag_hw] = live_n;
          if (tag_hw + 1 > tag_len) tag_len = tag_hw + 1;
          pos_tag[live_n] = tag_hw;
          if (live_n + 1 > pos_used) pos_used = live_n + 1;
          live_n++;
          v = tag_hw;
          tag_hw++;
        end
      end
      tdim_pkg::FUNC_REMOVE: begin
        idx = (ti < tag_len) ? tag_pos[ti] : -1;
        if (idx < 0 || idx >= ENTRY_N || live_n == 0) begin
          r.status = tdim_pkg::ST_NOT_PRESENT;
        end else begin
          // swap the last entry into the freed slot
          live_n--;
          moved = pos_tag[live_n];
          if (moved >= 0 && moved < TAG_N) tag_pos[moved] = idx;
          pos_tag[idx] = moved;
          tag_pos[ti] = -1;
          pos_tag[live_n] = -1;
          v = idx;
        end
      end
      tdim_pkg::FUNC_SET: begin
        if (pi >= pos_used || ti >= TAG_N) begin
          r.status = tdim_pkg::ST_POS_RANGE;
        end else begin
          old = pos_tag[pi];
          pos_tag[pi] = ti;
          if (ti + 1 > tag_len) tag_len = ti + 1;
          if (old >= 0 && old < TAG_N) tag_pos[old] = -1;
          tag_pos[ti] = pi;
          if (tag_hw <= ti) tag_hw = ti + 1;
          else if (old >= 0 && tag_hw - 1 == old) tag_hw--;
          v = old;
        end
      end
      tdim_pkg::FUNC_TAG_AT: begin
        if (pi >= live_n) begin
          r.status = tdim_pkg::ST_POS_RANGE;
          v = -2;
        end else begin
          v = pos_tag[pi];
        end
      end
      tdim_pkg::FUNC_POS_OF: begin
        if (ti >= tag_len) begin
          r.status = tdim_pkg::ST_NOT_PRESENT;
          v = -2;
        end else begin
          v = tag_pos[ti];
          if (v > -1) r.exists = 1'b1;
          else r.status = tdim_pkg::ST_NOT_PRESENT;
        end
      end
      default: ;
    endcase
    r.value = 13'(v);
    r.count = 11'(live_n);
    r.max_tag = 13'(tag_hw - 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // driver: predicts at each input transfer
  int tx_gap = 0;
  always @(posedge clk) begin
    map_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(),
                                slotmap_apply(in_func, in_tag, in_position));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          in_func <= op.func;
          in_tag <= op.tag;
          in_position <= op.pos;
          in_valid <= 1'b1;
          tx_gap <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: one long hold-off lets the block back up into its input
  int rx_wait = 0;
  always @(posedge clk) begin
    map_result_t e;
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no expectation, status", out_status, -1);
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_value !== e.value) report_mismatch("value", int'(out_value), int'(e.value));
        if (out_exists !== e.exists) report_mismatch("exists", out_exists, e.exists);
        if (out_entry_count !== e.count)
          report_mismatch("entry_count", out_entry_count, e.count);
        if (out_max_tag !== e.max_tag)
          report_mismatch("max_tag", int'(out_max_tag), int'(e.max_tag));
      end
      w = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap();
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (!out_ready) begin
      if (rx_wait <= 1) begin
        out_ready <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_op(input logic [2:0] f, input logic [11:0] t, input logic [9:0] p);
    map_op_t op;
    op.func = f;
    op.tag = t;
    op.pos = p;
    while (pending_ops.size() >= 2) @(posedge clk);
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // mostly live tags, some near the high-water mark, some anywhere
  function automatic logic [11:0] pick_tag();
    int k, t;
    k = $urandom_range(0, 9);
    if (k < 7 && live_n > 0) begin
      t = pos_tag[$urandom_range(0, live_n - 1)];
      if (t < 0) t = 0;
    end else if (k < 9) begin
      t = $urandom_range(0, (tag_hw + 2 > TAG_N - 1) ? TAG_N - 1 : tag_hw + 2);
    end else begin
      t = $urandom();
    end
    return 12'(t);
  endfunction

  initial begin
    int n, k, hi, ps4095;
    logic [2:0] f;
    logic [11:0] tg;
    logic [9:0] ps;
    for (n = 0; n < TAG_N; n++) tag_pos[n] = -1;
    for (n = 0; n < ENTRY_N; n++) pos_tag[n] = -1;
    live_n = 0;
    tag_hw = 0;
    tag_len = 0;
    pos_used = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty map, unused codes, adds, lookups, swap-remove, rebinding
    push_op(tdim_pkg::FUNC_TAG_AT, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_POS_OF, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_REMOVE, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_SET, 12'd0, 10'd0);
    push_op(3'd5, 12'hFFF, 10'h3FF);
    push_op(3'd6, 12'h000, 10'h000);
    push_op(3'd7, 12'hAAA, 10'h155);
    repeat (4) push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_POS_OF, 12'd2, 10'd0);
    push_op(tdim_pkg::FUNC_TAG_AT, 12'd0, 10'd3);
    push_op(tdim_pkg::FUNC_TAG_AT, 12'd0, 10'd4);
    push_op(tdim_pkg::FUNC_TAG_AT, 12'd0, 10'h3FF);
    push_op(tdim_pkg::FUNC_POS_OF, 12'hFFF, 10'd0);
    push_op(tdim_pkg::FUNC_REMOVE, 12'd1, 10'd0);
    push_op(tdim_pkg::FUNC_REMOVE, 12'd1, 10'd0);
    push_op(tdim_pkg::FUNC_POS_OF, 12'd1, 10'd0);
    // slot 3 is free now: rebinding there has no old tag to clear
    push_op(tdim_pkg::FUNC_SET, 12'd1, 10'd3);
    push_op(tdim_pkg::FUNC_SET, 12'd2, 10'd0);
    // slot 1 holds the newest tag, so rebinding it lowers the high-water mark
    push_op(tdim_pkg::FUNC_SET, 12'd0, 10'd1);
    push_op(tdim_pkg::FUNC_SET, 12'd9, 10'd2);
    push_op(tdim_pkg::FUNC_SET, 12'd5, 10'h3FF);

    // random mix with a back-to-back stretch without gaps and one full drain in the middle
    for (n = 0; n < RAND_ITEMS; n++) begin
      no_idle = (n >= 250 && n < 330);
      if (n == 400) wait_drained();
      k = $urandom_range(0, 99);
      tg = 12'($urandom());
      ps = 10'($urandom());
      if (k < 35) begin
        f = tdim_pkg::FUNC_ADD;
      end else if (k < 55) begin
        f = tdim_pkg::FUNC_REMOVE;
        tg = pick_tag();
      end else if (k < 65) begin
        f = tdim_pkg::FUNC_SET;
        if (pos_used > 0 && $urandom_range(0, 4) != 0)
          ps = 10'($urandom_range(0, pos_used - 1));
        hi = (tag_hw + 4 > 2047) ? 2047 : tag_hw + 4;
        tg = ($urandom_range(0, 2) == 0) ? pick_tag() : 12'($urandom_range(0, hi));
      end else if (k < 80) begin
        f = tdim_pkg::FUNC_TAG_AT;
        if ($urandom_range(0, 4) != 0) ps = 10'($urandom_range(0, live_n));
      end else if (k < 95) begin
        f = tdim_pkg::FUNC_POS_OF;
        tg = pick_tag();
      end else begin
        f = 3'($urandom_range(5, 7));
      end
      push_op(f, tg, ps);
    end
    no_idle = 1'b0;

    wait_drained();
    push_op(tdim_pkg::FUNC_TAG_AT, 12'd0, 10'h3FF);
    push_op(tdim_pkg::FUNC_REMOVE, pick_tag(), 10'd0);
    push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    // top tag pushes the high-water mark to the end, then adds are exhausted
    push_op(tdim_pkg::FUNC_SET, 12'hFFF,
            (pos_used > 0) ? 10'($urandom_range(0, pos_used - 1)) : 10'd0);
    push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_REMOVE, pick_tag(), 10'd0);
    push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    wait_drained();
    ps4095 = tag_pos[TAG_N - 1];
    if (ps4095 >= 0) push_op(tdim_pkg::FUNC_SET, 12'd3, 10'(ps4095));
    push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    push_op(tdim_pkg::FUNC_ADD, 12'd0, 10'd0);
    // unrestricted fields
    for (n = 0; n < 40; n++) push_op(3'($urandom()), 12'($urandom()), 10'($urandom()));

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 0, expected_results.size());
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
